// ===== sv/lph_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
// No dependencies; imported by every other file in sv/.
package lph_pkg;

  localparam int unsigned KEY_W           = 64;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned QUOTA_W         = 11;
  localparam int unsigned DEF_TABLE_DEPTH = 1024;

  // FNV-1a offset basis; only the low 16 bits of the prime matter for
  // indexes up to 16 bits, since its other set bit is bit 40.
  localparam logic [KEY_W-1:0] HASH_OFFSET   = 64'hcbf2_9ce4_8422_2325;
  localparam logic [15:0]      HASH_PRIME_LO = 16'h01b3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUOTA     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

// ===== sv/lph_hash.sv =====
// Home slot index: low bits of the single-step FNV-1a mix of a key.
// Depends on lph_pkg.
module lph_hash #(
  parameter int unsigned IDX_W = 10
) (
  input  logic [lph_pkg::KEY_W-1:0] key_i,
  output logic [IDX_W-1:0]          home_o
);
  import lph_pkg::*;

  logic [IDX_W-1:0] mix;

  // Bits below the index width only depend on bits below it, so the
  // 64x64 product reduces to a narrow one.
  assign mix    = key_i[IDX_W-1:0] ^ HASH_OFFSET[IDX_W-1:0];
  assign home_o = mix * HASH_PRIME_LO[IDX_W-1:0];

endmodule

// ===== sv/lph_mem.sv =====
// Slot memory: valid mark, key and value per entry; one write port and
// one read port with registered read data. Depends on lph_pkg.
module lph_mem #(
  parameter int unsigned DEPTH  = lph_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  lph_pkg::slot_t      wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output lph_pkg::slot_t      rdata_o
);
  import lph_pkg::*;

  slot_t slot_mem [DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= slot_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Linear-probe hash table, 64-bit keys to 32-bit values, top level.
// Depends on lph_pkg, lph_hash, lph_mem.
//
//   channel   ports                        handshake
//   request   req_i (command/key/value)    taken when start && !busy
//   result    rsp_o (status/read_value)    one cycle, marked by done_o
//   config    cfg_wdata_i (quota_limit)    written when cfg_we_i
//
// done_o is registered from the last probe step; 1 to TABLE_DEPTH slots
// are probed, and the single read port of the slot memory visits one slot
// per cycle. busy drops in the cycle done_o is high, so the next request can
// be taken at the edge ending it. After reset a clearing pass zeroes the
// valid marks with busy high; quota writes are taken throughout.
// Results cannot be stalled by the receiver.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = lph_pkg::DEF_TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lph_pkg::req_t               req_i,
  output logic                        done_o,
  output lph_pkg::rsp_t               rsp_o,
  input  logic                        cfg_we_i,
  input  logic [lph_pkg::QUOTA_W-1:0] cfg_wdata_i
);
  import lph_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > QUOTA_W) ? CNT_W : QUOTA_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   probe_q, probe_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [QUOTA_W-1:0] quota_q;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   wval_q;

  logic               req_acc;
  logic [IDX_W-1:0]   home;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  slot_t              mem_wdata, rd;
  logic               hit, quota_hit;

  assign req_acc = start && !busy;

  lph_hash #(
    .IDX_W (IDX_W)
  ) u_hash (
    .key_i  (req_i.key),
    .home_o (home)
  );

  lph_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  assign hit       = rd.valid && (rd.key == key_q);
  assign quota_hit = (quota_q != '0) && (CMP_W'(cnt_q) >= CMP_W'(quota_q));

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    probe_d   = probe_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '{valid: 1'b1, key: key_q, value: wval_q};
    mem_re    = 1'b0;
    mem_raddr = home;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mem_re    = 1'b1;
          mem_raddr = home;
          idx_d     = home;
          probe_d   = '0;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        // stop on key match, free slot, or after the last slot of a full wrap
        if (hit || !rd.valid || (&probe_q)) begin
          state_d          = S_IDLE;
          done_d           = 1'b1;
          rsp_d.read_value = '0;
          if (cmd_q == CMD_LOOKUP) begin
            rsp_d.status = hit ? ST_FOUND : ST_NOT_FOUND;
            if (hit) begin
              rsp_d.read_value = rd.value;
            end
          end else if (hit) begin
            mem_we       = 1'b1;
            rsp_d.status = ST_UPDATED;
          end else if (quota_hit) begin
            rsp_d.status = ST_QUOTA;
          end else if (!rd.valid) begin
            mem_we       = 1'b1;
            cnt_d        = cnt_q + 1'b1;
            rsp_d.status = ST_INSERTED;
          end else begin
            rsp_d.status = ST_FULL;
          end
        end else begin
          idx_d     = idx_q + 1'b1;
          probe_d   = probe_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      probe_q <= '0;
      clr_q   <= '0;
      cnt_q   <= '0;
      quota_q <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      probe_q <= probe_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      if (cfg_we_i) begin
        quota_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q  <= req_i.command;
      key_q  <= req_i.key;
      wval_q <= req_i.write_value;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= TABLE_DEPTH)
    else $error("entry count above table depth");

  a_insert_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == ST_INSERTED) |-> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not bump entry count");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_CHECK)
    else $error("result strobe without a probe step");

  a_no_idle_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != S_IDLE)
    else $error("slot write while idle");

  a_val_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != ST_FOUND) |-> rsp_o.read_value == '0)
    else $error("read value nonzero without a hit");

endmodule
